>>> sv/multi_box_bilinear_table_interp_top_defines.svh
// ----------------------------------------------------------------------------
// multi_box_bilinear_table_interp_top_defines
// assertion macros shared by the interpolator rtl
// ----------------------------------------------------------------------------
`ifndef MULTI_BOX_BILINEAR_TABLE_INTERP_TOP_DEFINES_SVH
`define MULTI_BOX_BILINEAR_TABLE_INTERP_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define MBBTI_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define MBBTI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MBBTI_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define MBBTI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> sv/mbbti_pkg.sv
// ----------------------------------------------------------------------------
// mbbti_pkg
// shared types and constants of the multi-box bilinear interpolator
// ----------------------------------------------------------------------------
package mbbti_pkg;

  localparam int MAX_BOXES     = 8;
  localparam int WORDS_PER_BOX = 6;
  localparam int SAMPLE_DEPTH  = 65536;

  localparam int DESC_DEPTH = MAX_BOXES * WORDS_PER_BOX;
  localparam int DESC_AW    = $clog2(DESC_DEPTH);
  localparam int SAMPLE_AW  = $clog2(SAMPLE_DEPTH);
  localparam int BOX_W      = $clog2(MAX_BOXES + 1);
  localparam int FLD_W      = $clog2(WORDS_PER_BOX);
  localparam int BASE_W     = 50;

  // shared divider: quotient bits, divisor bits, dividend bits
  localparam int DIV_QW = 34;
  localparam int DIV_DW = 33;
  localparam int DIV_NW = DIV_DW + DIV_QW - 1;
  localparam int DIV_CW = $clog2(DIV_QW);

  typedef logic [1:0] action_t;
  localparam action_t ACT_DESC   = 2'd0;
  localparam action_t ACT_SAMPLE = 2'd1;
  localparam action_t ACT_QUERY  = 2'd2;

  // register select, taken from paddr bit 2
  localparam logic REG_SCAN_ORDER = 1'b0;

  typedef enum logic [1:0] {
    STS_OK, STS_X_OUT, STS_Y_OUT, STS_ADDR
  } status_e;

  typedef struct packed {
    logic [1:0]         action;
    logic [15:0]        address;
    logic signed [31:0] write_value;
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] interp_value;
    status_e            status;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_FETCH, ST_MULX, ST_MULY, ST_MULB, ST_TEST, ST_RANGE,
    ST_DIVX, ST_DIVX_W, ST_DIVY, ST_DIVY_W, ST_AMUL, ST_ASUM, ST_ACHK,
    ST_SFETCH, ST_BMUL_A, ST_BMUL_B, ST_BDIV, ST_BDIV_W, ST_EMIT
  } state_e;

  typedef enum logic [4:0] {
    OP_NOP, OP_START, OP_FETCH, OP_MULX, OP_MULY, OP_MULB, OP_TEST,
    OP_DIVX, OP_TAKEX, OP_DIVY, OP_TAKEY, OP_AMUL, OP_ASUM, OP_SFETCH,
    OP_BMUL_A, OP_BMUL_B, OP_BDIV, OP_BTAKE
  } op_e;

  typedef enum logic [1:0] {
    BL_R1, BL_R2, BL_P
  } blend_e;

  typedef struct packed {
    op_e     op;
    blend_e  sel;
    logic    load;
    status_e code;
  } cmd_t;

  typedef struct packed {
    logic n_zero;
    logic fld_last;
    logic hit;
    logic last_box;
    logic x_out;
    logic y_out;
    logic div_busy;
    logic a_bad;
    logic s_last;
  } sts_t;

endpackage

>>> sv/mbbti_div.sv
// ----------------------------------------------------------------------------
// mbbti_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module mbbti_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [mbbti_pkg::DIV_NW-1:0]  num_i,
  input  logic [mbbti_pkg::DIV_DW-1:0]  den_i,
  output logic                          busy_o,
  output logic [mbbti_pkg::DIV_QW-1:0]  quo_o,
  output logic [mbbti_pkg::DIV_DW-1:0]  rem_o
);

  logic                          busy_q;
  logic [mbbti_pkg::DIV_CW-1:0]  cnt_q;
  logic [mbbti_pkg::DIV_NW-1:0]  rem_q;
  logic [mbbti_pkg::DIV_NW-1:0]  dsh_q;
  logic [mbbti_pkg::DIV_QW-1:0]  quo_q;
  logic [mbbti_pkg::DIV_NW:0]    diff;
  logic                          ge;

  assign diff = {1'b0, rem_q} - {1'b0, dsh_q};
  assign ge   = ~diff[mbbti_pkg::DIV_NW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= mbbti_pkg::DIV_CW'(mbbti_pkg::DIV_QW - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      dsh_q <= {den_i, (mbbti_pkg::DIV_QW - 1)'(0)};
      quo_q <= '0;
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= diff[mbbti_pkg::DIV_NW-1:0];
      end
      dsh_q <= dsh_q >> 1;
      quo_q <= {quo_q[mbbti_pkg::DIV_QW-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q[mbbti_pkg::DIV_DW-1:0];

endmodule

>>> sv/mbbti_dp.sv
// ----------------------------------------------------------------------------
// mbbti_dp
// datapath: descriptor and sample stores, box test, address, blends
// ----------------------------------------------------------------------------
module mbbti_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_acc_i,
  input  mbbti_pkg::in_item_t  in_item_i,
  input  logic                 scan_order_i,
  input  logic [3:0]           box_count_i,
  input  mbbti_pkg::cmd_t      cmd_i,
  output mbbti_pkg::sts_t      sts_o,
  output mbbti_pkg::out_item_t out_item_o
);

  logic [31:0] dmem [mbbti_pkg::DESC_DEPTH];
  logic [31:0] smem [mbbti_pkg::SAMPLE_DEPTH];

  logic signed [31:0] wd_q [mbbti_pkg::WORDS_PER_BOX];
  logic signed [31:0] sq_q [4];
  logic [mbbti_pkg::FLD_W-1:0]   fld_q;
  logic [mbbti_pkg::DESC_AW-1:0] ptr_q;
  logic [mbbti_pkg::BOX_W-1:0]   box_q;
  logic [1:0]                    sidx_q;

  logic signed [31:0] x_q, y_q;
  logic signed [64:0] prodx_q, prody_q;
  logic signed [63:0] prodb_q;
  logic signed [65:0] xfin_q, yfin_q;
  logic signed [mbbti_pkg::BASE_W-1:0] base_q;
  logic [mbbti_pkg::DIV_QW-1:0] icol_q, irow_q;
  logic [31:0] dx_q, dy_q;
  logic signed [66:0] aprod_q;
  logic signed [68:0] a_q;
  logic signed [64:0] pa_q, pb_q;
  logic signed [31:0] r1_q, r2_q, p_q;
  mbbti_pkg::out_item_t out_q;

  logic signed [31:0] ncols, xini, xd, nrows, yini, yd;
  logic signed [32:0] ncols_m1, nrows_m1;
  logic [mbbti_pkg::BOX_W-1:0] nbox;
  logic signed [65:0] bsum;
  logic signed [mbbti_pkg::BASE_W-1:0] bsat;
  logic x_lo, x_hi, y_lo, y_hi, hit;
  logic [32:0] xdiff, ydiff;
  logic signed [31:0] qa, qb, bd;
  logic [31:0] bf;
  logic signed [32:0] bdmf, bfs;
  logic signed [67:0] nsum, bnum;
  logic [mbbti_pkg::SAMPLE_AW-1:0] saddr;
  logic div_start, div_busy;
  logic [mbbti_pkg::DIV_NW-1:0] div_num;
  logic [mbbti_pkg::DIV_DW-1:0] div_den;
  logic [mbbti_pkg::DIV_QW-1:0] div_quo;
  logic [mbbti_pkg::DIV_DW-1:0] div_rem;
  logic [31:0] rq;

  localparam logic signed [65:0] BASE_LIM = 66'sh1_0000_0000_0000;

  assign ncols = wd_q[0];
  assign xini  = wd_q[1];
  assign xd    = wd_q[2];
  assign nrows = wd_q[3];
  assign yini  = wd_q[4];
  assign yd    = wd_q[5];

  assign ncols_m1 = 33'(ncols) - 33'sd1;
  assign nrows_m1 = 33'(nrows) - 33'sd1;

  assign nbox = (32'(box_count_i) > 32'(mbbti_pkg::MAX_BOXES)) ?
                mbbti_pkg::BOX_W'(mbbti_pkg::MAX_BOXES) : mbbti_pkg::BOX_W'(box_count_i);

  // saturating running sample base
  assign bsum = 66'(base_q) + 66'(prodb_q);
  always_comb begin
    if (bsum > BASE_LIM) begin
      bsat = mbbti_pkg::BASE_W'(BASE_LIM);
    end else if (bsum < -BASE_LIM) begin
      bsat = mbbti_pkg::BASE_W'(-BASE_LIM);
    end else begin
      bsat = mbbti_pkg::BASE_W'(bsum);
    end
  end

  assign x_lo = x_q >= xini;
  assign x_hi = x_q < xfin_q;
  assign y_lo = y_q >= yini;
  assign y_hi = y_q < yfin_q;
  assign hit  = scan_order_i ? (y_hi && x_lo && x_hi) : (x_hi && y_lo && y_hi);

  assign xdiff = 33'(x_q) - 33'(xini);
  assign ydiff = 33'(y_q) - 33'(yini);

  // blend operand select
  always_comb begin
    case (cmd_i.sel)
      mbbti_pkg::BL_R1: begin
        qa = sq_q[0];
        qb = sq_q[1];
        bd = xd;
        bf = dx_q;
      end
      mbbti_pkg::BL_R2: begin
        qa = sq_q[2];
        qb = sq_q[3];
        bd = xd;
        bf = dx_q;
      end
      default: begin
        qa = r1_q;
        qb = r2_q;
        bd = yd;
        bf = dy_q;
      end
    endcase
  end

  assign bdmf = $signed({1'b0, bd}) - $signed({1'b0, bf});
  assign bfs  = $signed({1'b0, bf});
  // round to nearest, ties up, biased so the quotient stays unsigned
  assign nsum = 68'(pa_q) + 68'(pb_q);
  assign bnum = (nsum <<< 1) + 68'($signed({1'b0, bd}))
              + (68'($signed({1'b0, bd})) <<< 32);

  always_comb begin
    case (cmd_i.op)
      mbbti_pkg::OP_DIVX: begin
        div_num = mbbti_pkg::DIV_NW'(xdiff);
        div_den = {1'b0, xd};
      end
      mbbti_pkg::OP_DIVY: begin
        div_num = mbbti_pkg::DIV_NW'(ydiff);
        div_den = {1'b0, yd};
      end
      default: begin
        div_num = bnum[mbbti_pkg::DIV_NW-1:0];
        div_den = {bd, 1'b0};
      end
    endcase
  end

  assign div_start = (cmd_i.op == mbbti_pkg::OP_DIVX) || (cmd_i.op == mbbti_pkg::OP_DIVY) ||
                     (cmd_i.op == mbbti_pkg::OP_BDIV);
  assign rq = div_quo[31:0] ^ 32'h8000_0000;

  mbbti_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  assign saddr = mbbti_pkg::SAMPLE_AW'(a_q)
               + (sidx_q[1] ? mbbti_pkg::SAMPLE_AW'(ncols) : '0)
               + mbbti_pkg::SAMPLE_AW'(sidx_q[0]);

  // stores
  always_ff @(posedge clk_i) begin
    if (in_acc_i && in_item_i.action == mbbti_pkg::ACT_DESC &&
        32'(in_item_i.address) < 32'(mbbti_pkg::DESC_DEPTH)) begin
      dmem[mbbti_pkg::DESC_AW'(in_item_i.address)] <= in_item_i.write_value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == mbbti_pkg::OP_FETCH) begin
      wd_q[fld_q] <= dmem[ptr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc_i && in_item_i.action == mbbti_pkg::ACT_SAMPLE &&
        32'(in_item_i.address) < 32'(mbbti_pkg::SAMPLE_DEPTH)) begin
      smem[mbbti_pkg::SAMPLE_AW'(in_item_i.address)] <= in_item_i.write_value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == mbbti_pkg::OP_SFETCH) begin
      sq_q[sidx_q] <= smem[saddr];
    end
  end

  // scan counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fld_q  <= '0;
      ptr_q  <= '0;
      box_q  <= '0;
      sidx_q <= '0;
    end else begin
      case (cmd_i.op)
        mbbti_pkg::OP_START: begin
          fld_q  <= '0;
          ptr_q  <= '0;
          box_q  <= '0;
          sidx_q <= '0;
        end
        mbbti_pkg::OP_FETCH: begin
          ptr_q <= ptr_q + 1'b1;
          fld_q <= (32'(fld_q) == mbbti_pkg::WORDS_PER_BOX - 1) ? '0 : fld_q + 1'b1;
        end
        mbbti_pkg::OP_TEST: begin
          if (!hit) begin
            box_q <= box_q + 1'b1;
          end
        end
        mbbti_pkg::OP_SFETCH: begin
          sidx_q <= sidx_q + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // arithmetic
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      mbbti_pkg::OP_START: begin
        x_q    <= in_item_i.x_coord;
        y_q    <= in_item_i.y_coord;
        base_q <= '0;
      end
      mbbti_pkg::OP_MULX: prodx_q <= xd * ncols_m1;
      mbbti_pkg::OP_MULY: begin
        prody_q <= yd * nrows_m1;
        xfin_q  <= 66'(xini) + 66'(prodx_q);
      end
      mbbti_pkg::OP_MULB: begin
        prodb_q <= ncols * nrows;
        yfin_q  <= 66'(yini) + 66'(prody_q);
      end
      mbbti_pkg::OP_TEST: begin
        if (!hit) begin
          base_q <= bsat;
        end
      end
      mbbti_pkg::OP_TAKEX: begin
        icol_q <= div_quo;
        dx_q   <= div_rem[31:0];
      end
      mbbti_pkg::OP_TAKEY: begin
        irow_q <= div_quo;
        dy_q   <= div_rem[31:0];
      end
      mbbti_pkg::OP_AMUL: aprod_q <= ncols * $signed({1'b0, irow_q});
      mbbti_pkg::OP_ASUM: begin
        a_q <= 69'(base_q) + 69'(aprod_q) + 69'($signed({1'b0, icol_q}));
      end
      mbbti_pkg::OP_BMUL_A: pa_q <= qa * bdmf;
      mbbti_pkg::OP_BMUL_B: pb_q <= qb * bfs;
      mbbti_pkg::OP_BTAKE: begin
        case (cmd_i.sel)
          mbbti_pkg::BL_R1: r1_q <= rq;
          mbbti_pkg::BL_R2: r2_q <= rq;
          default:          p_q  <= rq;
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_q.interp_value <= (cmd_i.code == mbbti_pkg::STS_OK) ? p_q : '0;
      out_q.status       <= cmd_i.code;
    end
  end

  assign sts_o.n_zero   = (nbox == '0);
  assign sts_o.fld_last = (32'(fld_q) == mbbti_pkg::WORDS_PER_BOX - 1);
  assign sts_o.hit      = hit;
  assign sts_o.last_box = (32'(box_q) + 1 >= 32'(nbox));
  assign sts_o.x_out    = !(x_lo && x_hi);
  assign sts_o.y_out    = !(y_lo && y_hi);
  assign sts_o.div_busy = div_busy;
  assign sts_o.a_bad    = (a_q < 69'sd0) ||
                          ((a_q + 69'(ncols) + 69'sd1) >= 69'(mbbti_pkg::SAMPLE_DEPTH));
  assign sts_o.s_last   = (sidx_q == 2'd3);
  assign out_item_o     = out_q;

endmodule

>>> sv/mbbti_ctrl.sv
// ----------------------------------------------------------------------------
// mbbti_ctrl
// query sequencer and output register control
// ----------------------------------------------------------------------------
`include "multi_box_bilinear_table_interp_top_defines.svh"

module mbbti_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            query_i,
  input  logic            scan_order_i,
  input  mbbti_pkg::sts_t sts_i,
  input  logic            out_stall_i,
  output mbbti_pkg::cmd_t cmd_o,
  output logic            in_stall_o,
  output logic            out_valid_o
);

  mbbti_pkg::state_e  state_q, state_d;
  mbbti_pkg::status_e code_q, code_d;
  mbbti_pkg::blend_e  blend_q, blend_d;
  logic               out_valid_q, out_valid_d;
  mbbti_pkg::status_e miss_code;

  assign miss_code = scan_order_i ? mbbti_pkg::STS_Y_OUT : mbbti_pkg::STS_X_OUT;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mbbti_pkg::ST_IDLE;
      code_q      <= mbbti_pkg::STS_OK;
      blend_q     <= mbbti_pkg::BL_R1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      code_q      <= code_d;
      blend_q     <= blend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    code_d      = code_q;
    blend_d     = blend_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o.op    = mbbti_pkg::OP_NOP;
    cmd_o.sel   = blend_q;
    cmd_o.load  = 1'b0;
    cmd_o.code  = code_q;
    case (state_q)
      mbbti_pkg::ST_IDLE: begin
        if (query_i) begin
          cmd_o.op = mbbti_pkg::OP_START;
          if (sts_i.n_zero) begin
            code_d  = miss_code;
            state_d = mbbti_pkg::ST_EMIT;
          end else begin
            state_d = mbbti_pkg::ST_FETCH;
          end
        end
      end
      mbbti_pkg::ST_FETCH: begin
        cmd_o.op = mbbti_pkg::OP_FETCH;
        if (sts_i.fld_last) begin
          state_d = mbbti_pkg::ST_MULX;
        end
      end
      mbbti_pkg::ST_MULX: begin
        cmd_o.op = mbbti_pkg::OP_MULX;
        state_d  = mbbti_pkg::ST_MULY;
      end
      mbbti_pkg::ST_MULY: begin
        cmd_o.op = mbbti_pkg::OP_MULY;
        state_d  = mbbti_pkg::ST_MULB;
      end
      mbbti_pkg::ST_MULB: begin
        cmd_o.op = mbbti_pkg::OP_MULB;
        state_d  = mbbti_pkg::ST_TEST;
      end
      mbbti_pkg::ST_TEST: begin
        cmd_o.op = mbbti_pkg::OP_TEST;
        if (sts_i.hit) begin
          state_d = mbbti_pkg::ST_RANGE;
        end else if (sts_i.last_box) begin
          code_d  = miss_code;
          state_d = mbbti_pkg::ST_EMIT;
        end else begin
          state_d = mbbti_pkg::ST_FETCH;
        end
      end
      mbbti_pkg::ST_RANGE: begin
        if (sts_i.x_out) begin
          code_d  = mbbti_pkg::STS_X_OUT;
          state_d = mbbti_pkg::ST_EMIT;
        end else if (sts_i.y_out) begin
          code_d  = mbbti_pkg::STS_Y_OUT;
          state_d = mbbti_pkg::ST_EMIT;
        end else begin
          state_d = mbbti_pkg::ST_DIVX;
        end
      end
      mbbti_pkg::ST_DIVX: begin
        cmd_o.op = mbbti_pkg::OP_DIVX;
        state_d  = mbbti_pkg::ST_DIVX_W;
      end
      mbbti_pkg::ST_DIVX_W: begin
        if (!sts_i.div_busy) begin
          cmd_o.op = mbbti_pkg::OP_TAKEX;
          state_d  = mbbti_pkg::ST_DIVY;
        end
      end
      mbbti_pkg::ST_DIVY: begin
        cmd_o.op = mbbti_pkg::OP_DIVY;
        state_d  = mbbti_pkg::ST_DIVY_W;
      end
      mbbti_pkg::ST_DIVY_W: begin
        if (!sts_i.div_busy) begin
          cmd_o.op = mbbti_pkg::OP_TAKEY;
          state_d  = mbbti_pkg::ST_AMUL;
        end
      end
      mbbti_pkg::ST_AMUL: begin
        cmd_o.op = mbbti_pkg::OP_AMUL;
        state_d  = mbbti_pkg::ST_ASUM;
      end
      mbbti_pkg::ST_ASUM: begin
        cmd_o.op = mbbti_pkg::OP_ASUM;
        state_d  = mbbti_pkg::ST_ACHK;
      end
      mbbti_pkg::ST_ACHK: begin
        if (sts_i.a_bad) begin
          code_d  = mbbti_pkg::STS_ADDR;
          state_d = mbbti_pkg::ST_EMIT;
        end else begin
          state_d = mbbti_pkg::ST_SFETCH;
        end
      end
      mbbti_pkg::ST_SFETCH: begin
        cmd_o.op = mbbti_pkg::OP_SFETCH;
        if (sts_i.s_last) begin
          blend_d = mbbti_pkg::BL_R1;
          state_d = mbbti_pkg::ST_BMUL_A;
        end
      end
      mbbti_pkg::ST_BMUL_A: begin
        cmd_o.op = mbbti_pkg::OP_BMUL_A;
        state_d  = mbbti_pkg::ST_BMUL_B;
      end
      mbbti_pkg::ST_BMUL_B: begin
        cmd_o.op = mbbti_pkg::OP_BMUL_B;
        state_d  = mbbti_pkg::ST_BDIV;
      end
      mbbti_pkg::ST_BDIV: begin
        cmd_o.op = mbbti_pkg::OP_BDIV;
        state_d  = mbbti_pkg::ST_BDIV_W;
      end
      mbbti_pkg::ST_BDIV_W: begin
        if (!sts_i.div_busy) begin
          cmd_o.op = mbbti_pkg::OP_BTAKE;
          case (blend_q)
            mbbti_pkg::BL_R1: begin
              blend_d = mbbti_pkg::BL_R2;
              state_d = mbbti_pkg::ST_BMUL_A;
            end
            mbbti_pkg::BL_R2: begin
              blend_d = mbbti_pkg::BL_P;
              state_d = mbbti_pkg::ST_BMUL_A;
            end
            default: begin
              code_d  = mbbti_pkg::STS_OK;
              state_d = mbbti_pkg::ST_EMIT;
            end
          endcase
        end
      end
      mbbti_pkg::ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = mbbti_pkg::ST_IDLE;
        end
      end
      default: state_d = mbbti_pkg::ST_IDLE;
    endcase
  end

  assign in_stall_o  = (state_q != mbbti_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

  `MBBTI_ASSERT_NEXT(a_query_leaves_idle, clk_i, rst_ni, query_i, state_q != mbbti_pkg::ST_IDLE)
  `MBBTI_ASSERT_IMPL(a_rise_from_emit, clk_i, rst_ni, $rose(out_valid_q), $past(state_q) == mbbti_pkg::ST_EMIT)
  `MBBTI_ASSERT_NEXT(a_div_runs, clk_i, rst_ni, state_q == mbbti_pkg::ST_BDIV, sts_i.div_busy)
  `MBBTI_ASSERT_IMPL(a_ok_after_all_blends, clk_i, rst_ni, (state_q == mbbti_pkg::ST_EMIT) && (code_q == mbbti_pkg::STS_OK), blend_q == mbbti_pkg::BL_P)

endmodule

>>> sv/multi_box_bilinear_table_interp_top.sv
// ----------------------------------------------------------------------------
// multi_box_bilinear_table_interp_top
// bilinear interpolation over a table of up to eight grid boxes
// ----------------------------------------------------------------------------
// Items on the input channel either load a box descriptor word or a grid
// sample (no result), or query a point (one result). A query scans the
// boxes in turn, with 6 descriptor reads and 4 arithmetic steps per box
// on the single-port descriptor store, and then makes five passes of the shared
// radix-2 divider (cell column, cell row, and three rounded blends).
// Queries that end in an error finish right after the failing check. One
// item is processed at a time; a finished result sits in the output register
// while the next item is accepted. scan_order is at byte address 0 and
// box_count at 4; write them only while the block is idle.
module multi_box_bilinear_table_interp_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  mbbti_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output mbbti_pkg::out_item_t out_item_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic            scan_q;
  logic [3:0]      count_q;
  logic            in_acc, query;
  mbbti_pkg::cmd_t cmd;
  mbbti_pkg::sts_t sts;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q  <= 1'b0;
      count_q <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == mbbti_pkg::REG_SCAN_ORDER) begin
        scan_q <= pwdata[0];
      end else begin
        count_q <= pwdata[3:0];
      end
    end
  end

  assign prdata = (paddr[2] == mbbti_pkg::REG_SCAN_ORDER) ? {31'b0, scan_q} : {28'b0, count_q};

  assign in_acc = in_valid_i && !in_stall_o;
  assign query  = in_acc && (in_item_i.action == mbbti_pkg::ACT_QUERY);

  mbbti_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .query_i      (query),
    .scan_order_i (scan_q),
    .sts_i        (sts),
    .out_stall_i  (out_stall_i),
    .cmd_o        (cmd),
    .in_stall_o   (in_stall_o),
    .out_valid_o  (out_valid_o)
  );

  mbbti_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_acc_i     (in_acc),
    .in_item_i    (in_item_i),
    .scan_order_i (scan_q),
    .box_count_i  (count_q),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_item_o   (out_item_o)
  );

endmodule
